### design/mrac_pkg.sv
// shared constants, types and status codes for the region allocation checker
`default_nettype none
package mrac_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int ADDR_W      = 32;
    localparam int END_W       = ADDR_W + 1;
    localparam int ENTRY_W     = ADDR_W + END_W;
    localparam int PADDR_W     = 3;

    localparam logic [0:0] REG_MEM_SIZE = 1'b0;

    localparam logic MODE_ALLOC  = 1'b0;
    localparam logic MODE_ACCESS = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BOUNDS   = 3'd1,
        ST_OVERLAP  = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOREGION = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN
    } t_state;

endpackage
`default_nettype wire

### design/memory_region_alloc_check_core.sv
// region allocation and access checker top level with apb config port
// sequence: bounds check, one ram read per stored region, scan close, then the result strobe
// a bounds failure skips the scan, an empty table ends it at once and a hit ends it early
// the table holds up to 16 regions, scanned through the single ram read port
// throughput: one request at a time, busy high from acceptance until the result strobe
// reset: synchronous active low, clears mem_size and the region count, table is not cleared
`default_nettype none
module memory_region_alloc_check_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mrac_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_mode,
    input  wire logic [31:0]                   i_base_addr,
    input  wire logic [31:0]                   i_span_len,
    output logic                               o_done,
    output logic                               o_ok,
    output logic      [2:0]                    o_status
);
    import mrac_pkg::*;

    t_state                r_state, n_state;
    logic [ADDR_W-1:0]     r_mem_size;
    logic                  r_mode;
    logic [ADDR_W-1:0]     r_lo;
    logic [END_W-1:0]      r_hi;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_ra, n_ra;
    logic                  r_cv, n_cv;
    logic                  r_done, n_done;
    logic                  r_ok, n_ok;
    t_status               r_status, n_status;

    logic                  accept;
    logic                  cfg_wr;
    logic                  re;
    logic                  we;
    logic [ENTRY_W-1:0]    rdata;
    logic [ADDR_W-1:0]     e_start;
    logic [END_W-1:0]      e_end;
    logic                  hit;

    assign accept = start && (r_state == S_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_MEM_SIZE) ? r_mem_size : 32'd0;
    assign busy   = (r_state != S_IDLE);

    assign e_start = rdata[ENTRY_W-1:END_W];
    assign e_end   = rdata[END_W-1:0];

    always_comb begin
        if (r_mode == MODE_ALLOC) begin
            hit = ({1'b0, r_lo} < e_end) && ({1'b0, e_start} < r_hi);
        end else begin
            hit = (e_start <= r_lo) && (r_hi <= e_end);
        end
    end

    mrac_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({r_lo, r_hi}),
        .i_re    (re),
        .i_raddr (r_ra[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mem_size <= '0;
            r_count    <= '0;
            r_cv       <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cv    <= n_cv;
            r_done  <= n_done;
            if (cfg_wr && (paddr[PADDR_W-1] == REG_MEM_SIZE)) begin
                r_mem_size <= pwdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra     <= n_ra;
        r_ok     <= n_ok;
        r_status <= n_status;
        if (accept) begin
            r_mode <= i_mode;
            r_lo   <= i_base_addr;
            r_hi   <= {1'b0, i_base_addr} + {1'b0, i_span_len};
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ra     = r_ra;
        n_cv     = 1'b0;
        n_done   = 1'b0;
        n_ok     = r_ok;
        n_status = r_status;
        re       = 1'b0;
        we       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_ra = '0;
                if ((r_mode == MODE_ALLOC) && (r_hi > {1'b0, r_mem_size})) begin
                    n_done   = 1'b1;
                    n_ok     = 1'b0;
                    n_status = ST_BOUNDS;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_ra < r_count) begin
                    re   = 1'b1;
                    n_ra = r_ra + 1'b1;
                    n_cv = 1'b1;
                end
                if (r_cv && hit) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    n_cv    = 1'b0;
                    if (r_mode == MODE_ALLOC) begin
                        n_ok     = 1'b0;
                        n_status = ST_OVERLAP;
                    end else begin
                        n_ok     = 1'b1;
                        n_status = ST_OK;
                    end
                end else if (!r_cv && (r_ra == r_count)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_mode == MODE_ACCESS) begin
                        n_ok     = 1'b0;
                        n_status = ST_NOREGION;
                    end else if (r_count >= CNT_W'(MAX_REGIONS)) begin
                        n_ok     = 1'b0;
                        n_status = ST_FULL;
                    end else begin
                        we       = 1'b1;
                        n_count  = r_count + 1'b1;
                        n_ok     = 1'b1;
                        n_status = ST_OK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_ok     = r_ok;
    assign o_status = r_status;

endmodule
`default_nettype wire

### design/mrac_ram.sv
// generic single write port ram with registered read
`default_nettype none
module mrac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### design/mrac_checker.sv
// port level checks for the region allocation checker
`default_nettype none
module mrac_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_done,
    input wire logic       o_ok,
    input wire logic [2:0] o_status
);
    import mrac_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted without going busy");

    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_ok == (o_status == ST_OK)))
        else $error("ok flag disagrees with status");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status <= ST_NOREGION))
        else $error("status code out of range");

    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    a_single_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

endmodule

bind memory_region_alloc_check_core mrac_checker u_mrac_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_ok     (o_ok),
    .o_status (o_status)
);
`default_nettype wire

### dv/region_table_checker.sv
// checker: mirrors the region table, predicts each verdict and compares the strobed results
`timescale 1ns / 1ps
module region_table_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_psel,
    input  wire logic                         i_penable,
    input  wire logic                         i_pwrite,
    input  wire logic [mrac_pkg::PADDR_W-1:0] i_paddr,
    input  wire logic [31:0]                  i_pwdata,
    input  wire logic [31:0]                  i_prdata,
    input  wire logic                         i_pready,
    input  wire logic                         i_start,
    input  wire logic                         i_busy,
    input  wire logic                         i_mode,
    input  wire logic [31:0]                  i_base_addr,
    input  wire logic [31:0]                  i_span_len,
    input  wire logic                         i_done,
    input  wire logic                         i_ok,
    input  wire logic [2:0]                   i_status,
    output int                                o_fail_cnt,
    output int                                o_pending,
    output int                                o_checked,
    output int                                o_stored,
    output int                                o_granted,
    output int                                o_full_cnt
);
    import mrac_pkg::*;

    logic [31:0]     mem_limit;
    logic [ADDR_W-1:0] tbl_lo [MAX_REGIONS];
    logic [END_W-1:0]  tbl_hi [MAX_REGIONS];
    int              tbl_cnt;
    t_status         verdict_q [$];

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
        o_checked  = 0;
        o_stored   = 0;
        o_granted  = 0;
        o_full_cnt = 0;
        mem_limit  = '0;
        tbl_cnt    = 0;
    end

    function automatic t_status region_verdict(input logic mode, input logic [31:0] base,
                                               input logic [31:0] len);
        logic [END_W-1:0] lo;
        logic [END_W-1:0] hi;
        t_status          st;
        lo = {1'b0, base};
        hi = {1'b0, base} + {1'b0, len};
        if (mode == MODE_ALLOC) begin
            if (hi > {1'b0, mem_limit}) begin
                st = ST_BOUNDS;
            end else begin
                st = ST_OK;
                for (int k = 0; k < tbl_cnt; k++) begin
                    if (lo < tbl_hi[k] && {1'b0, tbl_lo[k]} < hi) st = ST_OVERLAP;
                end
                if (st == ST_OK && tbl_cnt >= MAX_REGIONS) st = ST_FULL;
                if (st == ST_OK) begin
                    tbl_lo[tbl_cnt] = base;
                    tbl_hi[tbl_cnt] = hi;
                    tbl_cnt++;
                end
            end
        end else begin
            st = ST_NOREGION;
            for (int k = 0; k < tbl_cnt; k++) begin
                if ({1'b0, tbl_lo[k]} <= lo && hi <= tbl_hi[k]) st = ST_OK;
            end
        end
        return st;
    endfunction

    always @(posedge i_clk) begin
        t_status st;
        t_status want;
        if (!i_rst_n) begin
            mem_limit = '0;
            tbl_cnt   = 0;
            verdict_q.delete();
        end else begin
            if (i_done) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: result with nothing pending: ok %0b status %0d",
                             $time, i_ok, i_status);
                    o_fail_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    o_checked++;
                    if (i_ok !== (want == ST_OK)) begin
                        $display("%0t: ok mismatch: expected %0b actual %0b",
                                 $time, (want == ST_OK), i_ok);
                        o_fail_cnt++;
                    end
                    if (i_status !== want) begin
                        $display("%0t: status mismatch: expected %0d (%s) actual %0d",
                                 $time, want, want.name(), i_status);
                        o_fail_cnt++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                st = region_verdict(i_mode, i_base_addr, i_span_len);
                verdict_q.push_back(st);
                if (st == ST_OK && i_mode == MODE_ALLOC) o_stored++;
                if (st == ST_OK && i_mode == MODE_ACCESS) o_granted++;
                if (st == ST_FULL) o_full_cnt++;
            end
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == REG_MEM_SIZE && i_paddr[1:0] == 2'b00)
                        mem_limit = i_pwdata;
                end else if (i_paddr[2] == REG_MEM_SIZE && i_prdata !== mem_limit) begin
                    $display("%0t: mem_size readback mismatch: expected %h actual %h",
                             $time, mem_limit, i_prdata);
                    o_fail_cnt++;
                end
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

### dv/tb_top.sv
// testbench top: clock, reset, apb setup and request stimulus for the region allocation checker
`timescale 1ns / 1ps
module tb_top;
    import mrac_pkg::*;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               start   = 1'b0;
    logic               busy;
    logic               i_mode  = 1'b0;
    logic [31:0]        i_base_addr = '0;
    logic [31:0]        i_span_len  = '0;
    logic               o_done;
    logic               o_ok;
    logic [2:0]         o_status;

    int fail_cnt, pending, checked, stored, granted, full_cnt;

    logic [31:0] alloc_base_q [$];
    logic [31:0] alloc_len_q  [$];

    memory_region_alloc_check_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_base_addr (i_base_addr),
        .i_span_len  (i_span_len),
        .o_done      (o_done),
        .o_ok        (o_ok),
        .o_status    (o_status)
    );

    region_table_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .i_start     (start),
        .i_busy      (busy),
        .i_mode      (i_mode),
        .i_base_addr (i_base_addr),
        .i_span_len  (i_span_len),
        .i_done      (o_done),
        .i_ok        (o_ok),
        .i_status    (o_status),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_stored    (stored),
        .o_granted   (granted),
        .o_full_cnt  (full_cnt)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("[memory_region_alloc_check_core] ERROR");
        $finish;
    end

    task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_mem_size(input logic [31:0] value);
        apb_xfer(1'b1, {REG_MEM_SIZE, 2'b00}, value);
        apb_xfer(1'b0, {REG_MEM_SIZE, 2'b00}, '0);
    endtask

    // at a falling edge: present the request and hold it until busy is seen low at an edge
    task automatic issue(input logic mode, input logic [31:0] base, input logic [31:0] len);
        logic was_busy;
        logic taken;
        start       <= 1'b1;
        i_mode      <= mode;
        i_base_addr <= base;
        i_span_len  <= len;
        taken = 1'b0;
        while (!taken) begin
            was_busy = busy;
            @(posedge i_clk);
            taken = (was_busy === 1'b0);
            @(negedge i_clk);
        end
    endtask

    task automatic alloc_req(input logic [31:0] base, input logic [31:0] len);
        issue(MODE_ALLOC, base, len);
        alloc_base_q.push_back(base);
        alloc_len_q.push_back(len);
        if (alloc_base_q.size() > 64) begin
            void'(alloc_base_q.pop_front());
            void'(alloc_len_q.pop_front());
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0 || busy !== 1'b0) @(negedge i_clk);
    endtask

    task automatic run_random(input int n, input int idle_pct, input logic [31:0] win_base);
        int          roll;
        int          pick;
        logic [31:0] b;
        logic [31:0] l;
        logic [31:0] off;
        for (int i = 0; i < n; i++) begin
            while ($urandom_range(0, 99) < idle_pct) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                l = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 32'h7FF);
                alloc_req(win_base + $urandom_range(0, 32'h1FFFF), l);
            end else if (roll < 14) begin
                alloc_req($urandom, ($urandom_range(0, 1) != 0) ? $urandom
                                                               : $urandom_range(0, 255));
            end else if (roll < 85 && alloc_base_q.size() > 0) begin
                // access aimed at a requested region: inside, exact or just past an edge
                pick = $urandom_range(0, alloc_base_q.size() - 1);
                b = alloc_base_q[pick];
                l = alloc_len_q[pick];
                off = $urandom_range(0, l);
                case ($urandom_range(0, 4))
                    0: issue(MODE_ACCESS, b, l);
                    1: issue(MODE_ACCESS, b + off, $urandom_range(0, l - off));
                    2: issue(MODE_ACCESS, b + off, l - off + 32'd1);
                    3: issue(MODE_ACCESS, b - 32'd1, l + 32'd1);
                    default: issue(MODE_ACCESS, b + l, 32'd0);
                endcase
            end else begin
                issue(MODE_ACCESS, $urandom, ($urandom_range(0, 1) != 0) ? $urandom
                                                                        : $urandom_range(0, 255));
            end
        end
        drain();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // mem_size still zero after reset, table empty
        apb_xfer(1'b0, {REG_MEM_SIZE, 2'b00}, '0);
        issue(MODE_ACCESS, 32'h0, 32'h0);
        alloc_req(32'h0, 32'h1);
        drain();

        set_mem_size(32'h0001_0000);
        alloc_req(32'h100, 32'h100);
        alloc_req(32'h180, 32'h10);
        alloc_req(32'h200, 32'h10);
        alloc_req(32'h150, 32'h0);
        issue(MODE_ACCESS, 32'h100, 32'h100);
        issue(MODE_ACCESS, 32'h100, 32'h101);
        issue(MODE_ACCESS, 32'h200, 32'h0);
        issue(MODE_ACCESS, 32'h1FF, 32'h2);
        alloc_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        set_mem_size(32'hFFFF_FFFF);
        alloc_req(32'hFFFF_FFF0, 32'h10);
        alloc_req(32'hFFFF_FF00, 32'hFF);
        issue(MODE_ACCESS, 32'hFFFF_FF00, 32'hFF);
        issue(MODE_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(MODE_ACCESS, 32'h0, 32'hFFFF_FFFF);
        drain();

        // write to an address past the only register leaves mem_size alone
        apb_xfer(1'b1, 3'd4, 32'h0);
        apb_xfer(1'b0, {REG_MEM_SIZE, 2'b00}, '0);
        alloc_req(32'h1000, 32'h10);
        drain();

        set_mem_size(32'h0002_0000);
        run_random(283, 27, 32'h0);

        set_mem_size(32'hFFFF_FFFF);
        run_random(283, 80, 32'hFFFE_0000);

        set_mem_size($urandom | 32'h8000_0000);
        run_random(283, 0, $urandom_range(0, 32'h7FF0_0000));

        drain();
        repeat (24) @(negedge i_clk);

        $display("checked %0d requests against the region table model", checked);
        $display("%0d regions stored, %0d accesses granted, %0d refused on a full table",
                 stored, granted, full_cnt);
        if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
        if (fail_cnt == 0 && pending == 0) begin
            $display("[memory_region_alloc_check_core] OK");
        end else begin
            $display("[memory_region_alloc_check_core] ERROR");
        end
        $finish;
    end

endmodule

### memory_region_alloc_check_core.f
design/mrac_pkg.sv
design/mrac_ram.sv
design/memory_region_alloc_check_core.sv
design/mrac_checker.sv
dv/region_table_checker.sv
dv/tb_top.sv
